/* src/itoa_pkg.sv */
// Shared types and constants for the integer to ASCII radix converter.
package itoa_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SIGN = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_TERM = 5'b10000
    } t_state;

    localparam logic [7:0] RADIX_MIN    = 8'd2;
    localparam logic [7:0] RADIX_MAX    = 8'd16;
    localparam logic [7:0] RADIX_SIGNED = 8'd10;
    localparam logic [7:0] RADIX_RESET  = 8'd10;
    localparam logic [7:0] MINUS_CHAR   = 8'h2d;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam int unsigned DIGIT_BITS  = 4;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = 8'h30;
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h61;
            4'd11:   c = 8'h62;
            4'd12:   c = 8'h63;
            4'd13:   c = 8'h64;
            4'd14:   c = 8'h65;
            4'd15:   c = 8'h66;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

endpackage

/* src/integer_to_ascii_radix_top.sv */
// Integer to ASCII text converter, radix 2 to 16, top level.
// Sequence: the shared divider yields the digits, least significant first, then a minus sign
// is added for a negative value in radix 10, then the characters and the NUL go out at one per
// cycle while the output is not stalled; a radix out of range goes straight to the NUL.
// Throughput: one input transaction at a time; ready only while the sequencer is idle.
// Reset (synchronous, active low): sequencer idle, output empty, radix back to 10.
module integer_to_ascii_radix_top #(
    parameter int VALUE_BITS = 32,
    localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,   // [VALUE_BITS-1:0] value, rest zero fill
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] character
    output logic            m_axis_tlast
);

    localparam int DB     = itoa_pkg::DIGIT_BITS;
    localparam int MAG_W  = ((VALUE_BITS + DB - 1) / DB) * DB;
    localparam int STEPS  = MAG_W / DB;
    localparam int STEP_W = $clog2(STEPS);
    localparam int DEPTH  = VALUE_BITS + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    itoa_pkg::t_state r_state, n_state;
    logic [7:0]             r_radix;
    logic [MAG_W-1:0]       r_mag, n_mag;
    logic [DB-1:0]          r_rem, n_rem;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [CNT_W-1:0]       r_n, n_n;
    logic                   r_neg, n_neg;
    logic [DEPTH-1:0][7:0]  r_stk, n_stk;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;

    logic [MAG_W-1:0]       div_mag;
    logic [DB-1:0]          div_rem;
    logic [VALUE_BITS-1:0]  in_bits;
    logic [VALUE_BITS-1:0]  in_mag;
    logic                   radix_ok;
    logic                   load_ok;
    logic                   in_acc;

    assign s_axis_tready = (r_state == itoa_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_ok       = !r_out_valid || m_axis_tready;
    assign in_bits       = s_axis_tdata[VALUE_BITS-1:0];
    assign in_mag        = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;

    always_comb begin
        radix_ok = r_radix inside {[itoa_pkg::RADIX_MIN:itoa_pkg::RADIX_MAX]};
    end

    // shared divider: DB quotient bits per cycle
    always_comb begin
        logic [DB:0]   t;
        logic [DB-1:0] rem;
        logic [DB-1:0] q;
        logic [DB-1:0] blk;
        rem = r_rem;
        q   = '0;
        blk = r_mag[MAG_W-1 -: DB];
        for (int i = DB - 1; i >= 0; i--) begin
            t = {rem, blk[i]};
            if (t >= r_radix[DB:0]) begin
                q[i] = 1'b1;
                t    = t - r_radix[DB:0];
            end
            rem = t[DB-1:0];
        end
        div_rem = rem;
        div_mag = {r_mag[MAG_W-DB-1:0], q};
    end

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_step      = r_step;
        n_n         = r_n;
        n_neg       = r_neg;
        n_stk       = r_stk;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mag  = MAG_W'(in_mag);
                    n_neg  = in_bits[VALUE_BITS-1];
                    n_rem  = '0;
                    n_step = '0;
                    n_n    = '0;
                    n_state = radix_ok ? itoa_pkg::ST_DIV : itoa_pkg::ST_TERM;
                end
            end
            itoa_pkg::ST_DIV: begin
                n_mag = div_mag;
                n_rem = div_rem;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_stk  = {r_stk[DEPTH-2:0], itoa_pkg::digit_char(div_rem)};
                    n_n    = r_n + 1'b1;
                    n_rem  = '0;
                    n_step = '0;
                    if (div_mag != '0) begin
                        n_state = itoa_pkg::ST_DIV;
                    end else if (r_neg && r_radix == itoa_pkg::RADIX_SIGNED) begin
                        n_state = itoa_pkg::ST_SIGN;
                    end else begin
                        n_state = itoa_pkg::ST_EMIT;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            itoa_pkg::ST_SIGN: begin
                n_stk   = {r_stk[DEPTH-2:0], itoa_pkg::MINUS_CHAR};
                n_n     = r_n + 1'b1;
                n_state = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_stk[0];
                    n_out_last  = 1'b0;
                    n_stk       = {itoa_pkg::NUL_CHAR, r_stk[DEPTH-1:1]};
                    n_n         = r_n - 1'b1;
                    if (r_n == CNT_W'(1)) begin
                        n_state = itoa_pkg::ST_TERM;
                    end
                end
            end
            itoa_pkg::ST_TERM: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_data  = itoa_pkg::NUL_CHAR;
                    n_out_last  = 1'b1;
                    n_state     = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoa_pkg::ST_IDLE;
            r_radix     <= itoa_pkg::RADIX_RESET;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_step      <= n_step;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_stk      <= n_stk;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_n == '0)
        else $error("character stack not empty while idle");

    a_emit_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == itoa_pkg::ST_EMIT |-> r_n != '0)
        else $error("emitting from an empty character stack");

    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == itoa_pkg::NUL_CHAR)
        else $error("last transaction is not the terminator");

    a_bad_radix_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !radix_ok |=> r_state == itoa_pkg::ST_TERM)
        else $error("invalid radix did not go straight to terminator");
`endif

endmodule
